/* rtl/core/s256mp_pkg.sv */
// Shared types and constants of the SHA-256 message padder.
package s256mp_pkg;

    localparam int COUNT_W   = 61;
    localparam int PART_W    = 24;
    localparam int LEN_W     = 64;
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = 2;
    localparam int CMD_CW    = 3;

    localparam logic [7:0] PAD_MARK       = 8'h80;
    localparam logic [3:0] LAST_DATA_WORD = 4'd13;
    localparam logic [3:0] LEN_HI_WORD    = 4'd14;
    localparam logic [3:0] LEN_LO_WORD    = 4'd15;
    localparam logic [5:0] LAST_BLK_BYTE  = 6'd63;
    localparam logic [1:0] LAST_WRD_BYTE  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] word;
        logic        block_end;
        logic        message_end;
    } t_out_item;

    // word: full data word, or right-aligned partial bytes for a pad command
    // pos: byte position within the block of the word's last byte, or of
    // the next byte for a pad command
    typedef struct packed {
        logic             pad;
        logic [31:0]      word;
        logic [5:0]       pos;
        logic [LEN_W-1:0] bit_len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        BK_IDLE,
        BK_PAD
    } t_back_state;

endpackage

/* rtl/core/s256mp_front.sv */
// Front end: accepts bytes, assembles words, counts the message and issues pad commands.
module s256mp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  s256mp_pkg::t_in_item  i_item,
    input  s256mp_pkg::t_q_status i_q_status,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output s256mp_pkg::t_cmd      o_cmd
);

    logic [s256mp_pkg::COUNT_W-1:0] r_count, n_count;
    logic [s256mp_pkg::PART_W-1:0]  r_partial, n_partial;
    logic                           accept;

    assign o_full = i_q_status.full;
    assign accept = i_push && !i_q_status.full;

    always_comb begin
        n_count    = r_count;
        n_partial  = r_partial;
        o_cmd_push = 1'b0;
        o_cmd.pad     = i_item.kind;
        o_cmd.word    = {r_partial, i_item.data_byte};
        o_cmd.pos     = r_count[5:0];
        o_cmd.bit_len = {r_count, 3'b000};
        if (accept) begin
            if (i_item.kind) begin
                o_cmd.word = {8'h00, r_partial};
                o_cmd_push = 1'b1;
                n_count    = '0;
                n_partial  = '0;
            end else begin
                n_count = r_count + {{(s256mp_pkg::COUNT_W-1){1'b0}}, 1'b1};
                if (r_count[1:0] == s256mp_pkg::LAST_WRD_BYTE) begin
                    o_cmd_push = 1'b1;
                    n_partial  = '0;
                end else begin
                    n_partial = {r_partial[15:0], i_item.data_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_partial <= '0;
        end else begin
            r_count   <= n_count;
            r_partial <= n_partial;
        end
    end

endmodule

/* rtl/core/s256mp_cmd_fifo.sv */
// Short command queue between front end and back end.
module s256mp_cmd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  s256mp_pkg::t_cmd      i_cmd,
    input  logic                  i_pop,
    output s256mp_pkg::t_cmd      o_cmd,
    output s256mp_pkg::t_q_status o_status
);

    s256mp_pkg::t_cmd              r_mem [s256mp_pkg::CMD_DEPTH];
    logic [s256mp_pkg::CMD_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [s256mp_pkg::CMD_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [s256mp_pkg::CMD_CW-1:0] r_fill, n_fill;
    logic                          do_push, do_pop;

    assign o_status.full  = (r_fill == s256mp_pkg::CMD_CW'(s256mp_pkg::CMD_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/core/s256mp_back.sv */
// Back end: forwards data words and sequences the padding and length words.
module s256mp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  s256mp_pkg::t_cmd      i_cmd,
    input  s256mp_pkg::t_q_status i_q_status,
    output logic                  o_cmd_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output s256mp_pkg::t_out_item o_result
);

    s256mp_pkg::t_back_state       r_state, n_state;
    logic [3:0]                    r_idx, n_idx;
    logic                          r_first, n_first;
    logic                          r_lenblk, n_lenblk;
    logic [1:0]                    r_nbytes, n_nbytes;
    logic [s256mp_pkg::PART_W-1:0] r_partial, n_partial;
    logic [s256mp_pkg::LEN_W-1:0]  r_len, n_len;
    s256mp_pkg::t_out_item         r_out, emit_item;
    logic                          r_ovalid;
    logic                          load_ok, emit, last_word;

    function automatic logic [31:0] first_pad_word(input logic [1:0] nbytes,
                                                   input logic [23:0] part);
        logic [31:0] w;
        case (nbytes)
            2'd0:    w = {s256mp_pkg::PAD_MARK, 24'h000000};
            2'd1:    w = {part[7:0], s256mp_pkg::PAD_MARK, 16'h0000};
            2'd2:    w = {part[15:0], s256mp_pkg::PAD_MARK, 8'h00};
            default: w = {part, s256mp_pkg::PAD_MARK};
        endcase
        return w;
    endfunction

    assign load_ok   = !r_ovalid || i_pop;
    assign last_word = !r_first && r_lenblk && (r_idx == s256mp_pkg::LEN_LO_WORD);
    assign o_empty   = !r_ovalid;
    assign o_result  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            s256mp_pkg::BK_IDLE: begin
                if (!i_q_status.empty && i_cmd.pad) begin
                    n_state = s256mp_pkg::BK_PAD;
                end
            end
            s256mp_pkg::BK_PAD: begin
                if (load_ok && last_word) begin
                    n_state = s256mp_pkg::BK_IDLE;
                end
            end
            default: n_state = s256mp_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        emit_item = '0;
        n_idx     = r_idx;
        n_first   = r_first;
        n_lenblk  = r_lenblk;
        n_nbytes  = r_nbytes;
        n_partial = r_partial;
        n_len     = r_len;
        case (r_state)
            s256mp_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_cmd.pad) begin
                        o_cmd_pop = 1'b1;
                        n_idx     = i_cmd.pos[5:2];
                        n_nbytes  = i_cmd.pos[1:0];
                        n_partial = i_cmd.word[23:0];
                        n_len     = i_cmd.bit_len;
                        n_first   = 1'b1;
                        n_lenblk  = (i_cmd.pos[5:2] <= s256mp_pkg::LAST_DATA_WORD);
                    end else if (load_ok) begin
                        o_cmd_pop             = 1'b1;
                        emit                  = 1'b1;
                        emit_item.word        = i_cmd.word;
                        emit_item.block_end   = (i_cmd.pos == s256mp_pkg::LAST_BLK_BYTE);
                        emit_item.message_end = 1'b0;
                    end
                end
            end
            s256mp_pkg::BK_PAD: begin
                if (load_ok) begin
                    emit = 1'b1;
                    if (r_first) begin
                        emit_item.word = first_pad_word(r_nbytes, r_partial);
                    end else if (r_lenblk && r_idx == s256mp_pkg::LEN_HI_WORD) begin
                        emit_item.word = r_len[63:32];
                    end else if (r_lenblk && r_idx == s256mp_pkg::LEN_LO_WORD) begin
                        emit_item.word = r_len[31:0];
                    end else begin
                        emit_item.word = '0;
                    end
                    emit_item.block_end   = (r_idx == s256mp_pkg::LEN_LO_WORD);
                    emit_item.message_end = last_word;
                    n_first = 1'b0;
                    n_idx   = r_idx + 4'd1;
                    if (r_idx == s256mp_pkg::LEN_LO_WORD) begin
                        n_lenblk = 1'b1;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= s256mp_pkg::BK_IDLE;
            r_ovalid <= 1'b0;
            r_first  <= 1'b0;
            r_lenblk <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_lenblk <= n_lenblk;
            r_idx    <= n_idx;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nbytes  <= n_nbytes;
        r_partial <= n_partial;
        r_len     <= n_len;
        if (emit) begin
            r_out <= emit_item;
        end
    end

endmodule

/* rtl/core/sha256_message_padder_core.sv */
// Top level of the SHA-256 message padder.
// Usage:
//  Input queue: an item transfers when i_push is high and o_full is low.
//  kind 0 carries a message byte, kind 1 closes the message (byte ignored).
//  Result queue: o_result holds the oldest word while o_empty is low; it
//  transfers when i_pop is high. Words are big-endian, block_end marks the
//  sixteenth word of each 512-bit block, message_end the final padded word.
// Timing:
//  One byte per cycle is taken in while o_full is low. A word passes through the
//  command queue and the output register to o_result after its fourth byte transfers.
//  An end-of-message item is popped by the back end without output, then 3 to 18
//  padding and length words follow at one per cycle unless the receiver stalls;
//  the four-entry command queue keeps taking bytes of the next message meanwhile
//  and fills after four further words or end items, when o_full rises.
//  A stalled receiver holds the output register; the back end then stops
//  and the command queue fills, raising o_full.
// Reset: synchronous, active low; both queues empty, byte count cleared.
module sha256_message_padder_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  s256mp_pkg::t_in_item  i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output s256mp_pkg::t_out_item o_result
);

    s256mp_pkg::t_cmd      cmd_wr, cmd_rd;
    s256mp_pkg::t_q_status q_status;
    logic                  cmd_push, cmd_pop;

    s256mp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_full     (o_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_wr)
    );

    s256mp_cmd_fifo u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_cmd    (cmd_wr),
        .i_pop    (cmd_pop),
        .o_cmd    (cmd_rd),
        .o_status (q_status)
    );

    s256mp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_rd),
        .i_q_status (q_status),
        .o_cmd_pop  (cmd_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_result   (o_result)
    );

`ifndef ASSERT_OFF
    a_msg_end_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_result.message_end |-> o_result.block_end)
        else $error("message end outside block end");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !q_status.full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    a_pad_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push && cmd_wr.pad |-> i_push && i_item.kind)
        else $error("pad command without end-of-message transfer");
`endif

endmodule
